/* sv/tht_pkg.sv */
`timescale 1ns / 1ps

package tht_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int FIELD_W             = 16;
    localparam int ANGLE_W             = 8;
    localparam int MAG_W               = 7;
    localparam int THR_W               = 7;
    localparam int FRAC_BITS           = 20;
    localparam int TAN_W               = 26;
    localparam int RIGHT_ANGLE         = 90;
    localparam int IN_DATA_W           = 80;
    localparam int IN_USER_W           = 2;
    localparam int OUT_DATA_W          = 32;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 7'd5;
    localparam logic [MAG_W-1:0] ANGLE_LIMIT     = 7'd90;
    localparam logic [MAG_W-1:0] TAN_LAST        = 7'd89;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_POLL   = 1'b1;

    typedef enum logic [1:0] {
        NC_NONE  = 2'd0,
        NC_ROLL  = 2'd1,
        NC_PITCH = 2'd2,
        NC_YAW   = 2'd3
    } next_code_t;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } atan_res_t;

    typedef logic [RIGHT_ANGLE-1:0][TAN_W-1:0] tan_tab_t;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
    localparam logic [63:0] DEG_Q62 = PI_Q62 / 64'd180;

    // The functions below only run at elaboration to build the tangent table.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Restoring long division; returns the quotient above the remainder.
    function automatic logic [127:0] divmod(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    function automatic logic [63:0] series_q62(input logic [63:0] x, input logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [63:0] sum;
        logic               neg;
        logic [127:0]       qr;
        x2   = mul_q62(x, x);
        term = odd ? x : ONE_Q62;
        n    = odd ? 64'd1 : 64'd0;
        sum  = '0;
        neg  = 1'b0;
        while (term != 64'd0 && n < 64'd60)
        begin
            sum  = neg ? sum - $signed(term) : sum + $signed(term);
            qr   = divmod(mul_q62(term, x2), (n + 64'd1) * (n + 64'd2));
            term = qr[127:64];
            n    = n + 64'd2;
            neg  = !neg;
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    function automatic logic [31:0] ratio_q20(input logic [63:0] n, input logic [63:0] d);
        logic [63:0]  q;
        logic [63:0]  r;
        logic [127:0] qr;
        qr = divmod(n, d);
        q  = qr[127:64];
        r  = qr[63:0];
        for (int i = 0; i < 21; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        return 32'((q + 64'd1) >> 1);
    endfunction

    function automatic tan_tab_t build_tan();
        tan_tab_t    tab;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] c;
        int          a;
        for (int k = 0; k < RIGHT_ANGLE; k++)
        begin
            a = (k <= 45) ? k : (RIGHT_ANGLE - k);
            x = DEG_Q62 * 64'(a);
            s = series_q62(x, 1'b1);
            c = series_q62(x, 1'b0);
            tab[k] = (k <= 45) ? TAN_W'(ratio_q20(s, c)) : TAN_W'(ratio_q20(c, s));
        end
        return tab;
    endfunction

    localparam tan_tab_t TAN_TABLE = build_tan();

endpackage

/* sv/tht_atan_unit.sv */
`timescale 1ns / 1ps

module tht_atan_unit #(
    parameter int SAMPLE_BITS = tht_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] num,
    input  logic signed [SAMPLE_BITS-1:0] den,
    output tht_pkg::atan_res_t            res
);

    localparam int PROD_W = tht_pkg::TAN_W + SAMPLE_BITS;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_CMP,
        U_FIN
    } ustate_t;

    ustate_t                       state_reg;
    logic [tht_pkg::MAG_W-1:0]     k_reg;
    logic [2:0]                    idx_reg;
    logic                          neg_reg;
    logic [SAMPLE_BITS-1:0]        nm_reg;
    logic [SAMPLE_BITS-1:0]        dm_reg;
    logic [PROD_W-1:0]             prod_reg;

    logic [tht_pkg::MAG_W-1:0]     cand;
    logic [tht_pkg::TAN_W-1:0]     tan_val;
    logic [PROD_W-1:0]             limit;

    // The search sets one bit of the angle per multiply and compare pass.
    assign cand    = k_reg | (tht_pkg::MAG_W'(1) << idx_reg);
    assign tan_val = (cand <= tht_pkg::TAN_LAST) ? tht_pkg::TAN_TABLE[cand] : '0;
    assign limit   = PROD_W'({nm_reg, tht_pkg::FRAC_BITS'(0)});

    assign res.done  = (state_reg == U_FIN);
    assign res.angle = (neg_reg && k_reg != '0) ? -tht_pkg::ANGLE_W'(k_reg)
                                                : tht_pkg::ANGLE_W'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            k_reg     <= '0;
            idx_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        nm_reg  <= num[SAMPLE_BITS-1] ? SAMPLE_BITS'(-num) : SAMPLE_BITS'(num);
                        dm_reg  <= den[SAMPLE_BITS-1] ? SAMPLE_BITS'(-den) : SAMPLE_BITS'(den);
                        idx_reg <= 3'd6;
                        if (den == '0)
                        begin
                            k_reg     <= tht_pkg::ANGLE_LIMIT;
                            neg_reg   <= 1'b0;
                            state_reg <= U_FIN;
                        end
                        else
                        begin
                            k_reg     <= '0;
                            neg_reg   <= num[SAMPLE_BITS-1] ^ den[SAMPLE_BITS-1];
                            state_reg <= U_MUL;
                        end
                    end
                end
                U_MUL:
                begin
                    prod_reg  <= PROD_W'(tan_val) * PROD_W'(dm_reg);
                    state_reg <= U_CMP;
                end
                U_CMP:
                begin
                    if (cand <= tht_pkg::TAN_LAST && prod_reg <= limit)
                    begin
                        k_reg <= cand;
                    end
                    if (idx_reg == 3'd0)
                    begin
                        state_reg <= U_FIN;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 3'd1;
                        state_reg <= U_MUL;
                    end
                end
                U_FIN:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/tilt_heading_angle_tracker.sv */
`timescale 1ns / 1ps

// Tilt and heading angle tracker.
// Each transfer on the s_axis channel is either a sensor sample or a poll, told
// apart by tuser. A good sample updates roll, pitch and yaw in whole degrees and
// flags every angle whose magnitude moved by more than the change threshold.
// A poll returns and clears the first set flag in the order roll, pitch, yaw.
// Every input transfer yields exactly one m_axis transfer with the current angles.
// Each angle goes through the shared arctangent unit, which runs a
// seven-step bit search of one multiply state and one compare state per step;
// an angle whose divisor is zero skips the search.
// A poll or a sample with a bus error does not use the arctangent unit and
// goes straight to the output state.
// s_axis_tready is high only while no item is in work, one item at a time.
// The result sits in an output register, so a new item is accepted while it
// waits; a finished item waits until the receiver takes the earlier result.
// The cfg channel is always ready and loads the change threshold.
// Reset clears the angles and flags and sets the threshold to 5 degrees.

module tilt_heading_angle_tracker #(
    parameter int SAMPLE_BITS = tht_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, 16 bits each.
    input  logic [tht_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func, read_ok.
    input  logic [tht_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // roll_out, pitch_out, yaw_out, changed_mask, next_changed, zero fill.
    output logic [tht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tht_pkg::THR_W-1:0]        cfg_data
);

    localparam int FW = tht_pkg::FIELD_W;
    localparam int AW = tht_pkg::ANGLE_W;
    localparam int MW = tht_pkg::MAG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL,
        ST_PITCH,
        ST_YAW,
        ST_OUT
    } state_t;

    state_t                          state_reg;
    logic signed [AW-1:0]            roll_reg;
    logic signed [AW-1:0]            pitch_reg;
    logic signed [AW-1:0]            yaw_reg;
    logic [2:0]                      flags_reg;
    logic [tht_pkg::THR_W-1:0]       thr_reg;
    logic [2:0]                      mask_reg;
    tht_pkg::next_code_t             next_reg;
    logic signed [SAMPLE_BITS-1:0]   ay_reg;
    logic signed [SAMPLE_BITS-1:0]   az_reg;
    logic signed [SAMPLE_BITS-1:0]   mx_reg;
    logic signed [SAMPLE_BITS-1:0]   my_reg;
    logic signed [SAMPLE_BITS-1:0]   num_reg;
    logic signed [SAMPLE_BITS-1:0]   den_reg;
    logic                            start_reg;
    logic                            m_valid_reg;
    logic [tht_pkg::OUT_DATA_W-1:0]  m_data_reg;

    tht_pkg::atan_res_t              res;
    logic                            in_xfer;
    logic                            out_free;
    logic signed [AW-1:0]            old_angle;
    logic [MW-1:0]                   old_mag;
    logic [MW-1:0]                   new_mag;
    logic [MW-1:0]                   diff;
    logic                            exceed;
    logic signed [SAMPLE_BITS-1:0]   ax_in;
    logic signed [SAMPLE_BITS-1:0]   ay_in;
    logic signed [SAMPLE_BITS-1:0]   az_in;
    logic signed [SAMPLE_BITS-1:0]   mx_in;
    logic signed [SAMPLE_BITS-1:0]   my_in;

    tht_atan_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_atan (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start_reg),
        .num  (num_reg),
        .den  (den_reg),
        .res  (res)
    );

    // Raw fields are taken as SAMPLE_BITS-bit two's complement values.
    assign ax_in = SAMPLE_BITS'(s_axis_tdata[FW-1:0]);
    assign ay_in = SAMPLE_BITS'(s_axis_tdata[2*FW-1:FW]);
    assign az_in = SAMPLE_BITS'(s_axis_tdata[3*FW-1:2*FW]);
    assign mx_in = SAMPLE_BITS'(s_axis_tdata[4*FW-1:3*FW]);
    assign my_in = SAMPLE_BITS'(s_axis_tdata[5*FW-1:4*FW]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        unique case (state_reg)
            ST_PITCH: old_angle = pitch_reg;
            ST_YAW:   old_angle = yaw_reg;
            default:  old_angle = roll_reg;
        endcase
        old_mag = old_angle[AW-1] ? MW'(-old_angle) : old_angle[MW-1:0];
        new_mag = res.angle[AW-1] ? MW'(-res.angle) : res.angle[MW-1:0];
        diff    = (old_mag > new_mag) ? old_mag - new_mag : new_mag - old_mag;
        exceed  = (diff > thr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            flags_reg   <= '0;
            thr_reg     <= tht_pkg::THRESHOLD_RESET;
            mask_reg    <= '0;
            next_reg    <= tht_pkg::NC_NONE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        mask_reg <= '0;
                        next_reg <= tht_pkg::NC_NONE;
                        if (s_axis_tuser[0] == tht_pkg::FUNC_POLL)
                        begin
                            priority if (flags_reg[0])
                            begin
                                flags_reg[0] <= 1'b0;
                                next_reg     <= tht_pkg::NC_ROLL;
                            end
                            else if (flags_reg[1])
                            begin
                                flags_reg[1] <= 1'b0;
                                next_reg     <= tht_pkg::NC_PITCH;
                            end
                            else if (flags_reg[2])
                            begin
                                flags_reg[2] <= 1'b0;
                                next_reg     <= tht_pkg::NC_YAW;
                            end
                            else
                            begin
                                next_reg     <= tht_pkg::NC_NONE;
                            end
                            state_reg <= ST_OUT;
                        end
                        else if (s_axis_tuser[1])
                        begin
                            ay_reg    <= ay_in;
                            az_reg    <= az_in;
                            mx_reg    <= mx_in;
                            my_reg    <= my_in;
                            num_reg   <= az_in;
                            den_reg   <= ax_in;
                            start_reg <= 1'b1;
                            state_reg <= ST_ROLL;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_ROLL:
                begin
                    if (res.done)
                    begin
                        roll_reg     <= res.angle;
                        mask_reg[0]  <= exceed;
                        flags_reg[0] <= flags_reg[0] | exceed;
                        num_reg      <= az_reg;
                        den_reg      <= ay_reg;
                        start_reg    <= 1'b1;
                        state_reg    <= ST_PITCH;
                    end
                end
                ST_PITCH:
                begin
                    if (res.done)
                    begin
                        pitch_reg    <= res.angle;
                        mask_reg[1]  <= exceed;
                        flags_reg[1] <= flags_reg[1] | exceed;
                        num_reg      <= my_reg;
                        den_reg      <= mx_reg;
                        start_reg    <= 1'b1;
                        state_reg    <= ST_YAW;
                    end
                end
                ST_YAW:
                begin
                    if (res.done)
                    begin
                        yaw_reg      <= res.angle;
                        mask_reg[2]  <= exceed;
                        flags_reg[2] <= flags_reg[2] | exceed;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= {3'b000, next_reg, mask_reg, yaw_reg, pitch_reg, roll_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/tht_checker.sv */
`timescale 1ns / 1ps

module tht_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tht_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic signed [7:0] roll;
    logic signed [7:0] pitch;
    logic signed [7:0] yaw;
    logic [2:0]        mask;
    logic [1:0]        next_code;

    assign roll      = m_axis_tdata[7:0];
    assign pitch     = m_axis_tdata[15:8];
    assign yaw       = m_axis_tdata[23:16];
    assign mask      = m_axis_tdata[26:24];
    assign next_code = m_axis_tdata[28:27];

    // Only one item is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (roll >= -8'sd90 && roll <= 8'sd90 &&
                           pitch >= -8'sd90 && pitch <= 8'sd90 &&
                           yaw >= -8'sd90 && yaw <= 8'sd90))
        else $error("angle out of range");

    // A poll answer never comes with a change mask.
    a_poll_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && next_code != 2'd0 |-> mask == 3'd0)
        else $error("poll result carries a change mask");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind tilt_heading_angle_tracker tht_checker u_tht_checker (.*);
